@@ sv/dpia_pkg.sv @@
// Shared types and constants for the dual peripheral adapter port block.
`default_nettype none
package dpia_pkg;

    // Item commands
    typedef enum logic [2:0] {
        CMD_READ  = 3'd0,
        CMD_WRITE = 3'd1,
        CMD_HSYNC = 3'd2,
        CMD_VSYNC = 3'd3,
        CMD_CASS  = 3'd4,
        CMD_CART  = 3'd5
    } t_cmd;

    // Sync edge kinds
    localparam logic [1:0] EDGE_FALL = 2'd0;
    localparam logic [1:0] EDGE_RISE = 2'd1;
    localparam logic [1:0] EDGE_ANY  = 2'd2;

    // Fast interrupt actions
    localparam logic [1:0] FIRQ_NONE     = 2'd0;
    localparam logic [1:0] FIRQ_ASSERT   = 2'd1;
    localparam logic [1:0] FIRQ_DEASSERT = 2'd2;

    // Register addresses within one adapter
    localparam logic [1:0] ADDR_A_DATA = 2'd0;
    localparam logic [1:0] ADDR_A_CTRL = 2'd1;
    localparam logic [1:0] ADDR_B_DATA = 2'd2;
    localparam logic [1:0] ADDR_B_CTRL = 2'd3;

    // Configuration register indexes
    localparam logic CFG_CART_INSERTED  = 1'b0;
    localparam logic CFG_CART_AUTOSTART = 1'b1;

    // Control byte masks
    localparam logic [7:0] CTRL_WRITE_MASK = 8'h3F;
    localparam logic [7:0] CTRL_FLAG_CLEAR = 8'h3F;
    localparam logic [7:0] DAC_TOP_CLEAR   = 8'h7F;
    localparam logic [5:0] DAC_FULL        = 6'd63;

    // Architectural state of both adapters plus capture registers
    typedef struct packed {
        logic [3:0][7:0] f_regs;
        logic [7:0]      f_dir_a;
        logic [7:0]      f_dir_b;
        logic [3:0][7:0] s_regs;
        logic [7:0]      s_dir_a;
        logic [7:0]      s_dir_b;
        logic            charge_high;
        logic [6:0]      audio;
        logic [7:0]      cassette;
        logic            sound;
        logic            discharge;
    } t_state;

    // One input item
    typedef struct packed {
        t_cmd       cmd;
        logic [2:0] reg_index;
        logic [7:0] write_data;
        logic [1:0] edge_kind;
        logic [7:0] keyboard_rows;
    } t_item;

    // One result item
    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_assert;
        logic [1:0] firq_action;
        logic [5:0] dac_level;
        logic [1:0] mux_select;
        logic [4:0] video_mode;
        logic       motor_on;
        logic [6:0] audio_level;
        logic [7:0] cassette_level;
        logic       sound_level;
        logic [7:0] keyboard_column;
        logic       discharge_seen;
    } t_result;

    // Cartridge interrupt enable pair
    typedef struct packed {
        logic inserted;
        logic autostart;
    } t_cart_cfg;

endpackage
`default_nettype wire

@@ sv/dual_pia_port_block_core.sv @@
// Top level of the dual peripheral adapter port block.
//
// Input channel: one bus access or sync event per transfer (i_in_valid,
// o_in_stall). Output channel: one result per input transfer (o_out_valid,
// i_out_stall) carrying read data, interrupt actions and status levels.
// Configuration: i_cfg_we writes i_cfg_data[0] to the register picked by
// i_cfg_index (0 cart inserted, 1 cart autostart) at the clock edge.
// Result: registered, and presented in the cycle after the input transfer.
// Throughput: one item per cycle while the output is not stalled; the adapter
// state is updated by a single level of logic into the state and result
// registers, so the next item can follow immediately.
// Stall: while a result waits under i_out_stall, o_in_stall is raised;
// as soon as the result is taken a new item is accepted in the same cycle.
// Reset (synchronous, active low): all adapter registers and captured
// levels clear, cart inserted clears, cart autostart sets, output is empty.
`default_nettype none
module dual_pia_port_block_core
    import dpia_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire        i_cfg_index,
    input  wire        i_cfg_data,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire  [2:0] i_command,
    input  wire  [2:0] i_reg_index,
    input  wire  [7:0] i_write_data,
    input  wire  [1:0] i_edge_kind,
    input  wire  [7:0] i_keyboard_rows,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic [7:0] o_read_data,
    output logic       o_irq_assert,
    output logic [1:0] o_firq_action,
    output logic [5:0] o_dac_level,
    output logic [1:0] o_mux_select,
    output logic [4:0] o_video_mode,
    output logic       o_motor_on,
    output logic [6:0] o_audio_level,
    output logic [7:0] o_cassette_level,
    output logic       o_sound_level,
    output logic [7:0] o_keyboard_column,
    output logic       o_discharge_seen
);

    t_state    r_state;
    t_state    n_state;
    t_result   r_result;
    t_result   n_result;
    t_item     item;
    t_cart_cfg r_cart;
    logic      r_out_valid;
    logic      in_accept;

    // Input transfer handshake
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign item.cmd           = t_cmd'(i_command);
    assign item.reg_index     = i_reg_index;
    assign item.write_data    = i_write_data;
    assign item.edge_kind     = i_edge_kind;
    assign item.keyboard_rows = i_keyboard_rows;

    dpia_step u_step (
        .i_state  (r_state),
        .i_item   (item),
        .i_cart   (r_cart),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cart.inserted  <= 1'b0;
            r_cart.autostart <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CART_INSERTED:  r_cart.inserted  <= i_cfg_data;
                CFG_CART_AUTOSTART: r_cart.autostart <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Adapter state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register, payload only
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_read_data       = r_result.read_data;
    assign o_irq_assert      = r_result.irq_assert;
    assign o_firq_action     = r_result.firq_action;
    assign o_dac_level       = r_result.dac_level;
    assign o_mux_select      = r_result.mux_select;
    assign o_video_mode      = r_result.video_mode;
    assign o_motor_on        = r_result.motor_on;
    assign o_audio_level     = r_result.audio_level;
    assign o_cassette_level  = r_result.cassette_level;
    assign o_sound_level     = r_result.sound_level;
    assign o_keyboard_column = r_result.keyboard_column;
    assign o_discharge_seen  = r_result.discharge_seen;

    // Discharge flag is sticky until reset
    a_discharge_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_state.discharge) && $past(i_rst_n) |-> r_state.discharge)
        else $error("discharge flag cleared without reset");

    // IRQ only comes from sync edge commands
    a_irq_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_command != CMD_HSYNC && i_command != CMD_VSYNC
        |=> !o_irq_assert)
        else $error("irq pulse from a non-sync command");

    // Only read commands return data
    a_read_only_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_command != CMD_READ |=> o_read_data == 8'd0)
        else $error("nonzero read data for a non-read command");

    // Input stall only while a result is held
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output register");

endmodule
`default_nettype wire

@@ sv/dpia_step.sv @@
// Next-state and result logic for one item of the dual adapter block.
`default_nettype none
module dpia_step
    import dpia_pkg::*;
(
    input  var t_state    i_state,
    input  var t_item     i_item,
    input  var t_cart_cfg i_cart,
    output t_state        o_state,
    output t_result       o_result
);

    logic [1:0] addr;
    logic       second;
    logic       mux_zero;
    logic [5:0] level;
    logic [7:0] masked;
    logic       hit;

    always_comb begin
        o_state  = i_state;
        addr     = i_item.reg_index[1:0];
        second   = i_item.reg_index[2];
        mux_zero = !i_state.f_regs[ADDR_A_CTRL][3] && !i_state.f_regs[ADDR_B_CTRL][3];
        level    = i_item.write_data[7:2];
        masked   = i_item.write_data & i_state.s_dir_b;
        hit      = 1'b0;
        o_result = '0;

        case (i_item.cmd)
            // Register read; a data read clears the two flags
            CMD_READ: begin
                if (!second) begin
                    case (addr)
                        ADDR_A_DATA: begin
                            if (i_state.f_regs[ADDR_A_CTRL][2]) begin
                                o_state.f_regs[ADDR_A_CTRL] =
                                    i_state.f_regs[ADDR_A_CTRL] & CTRL_FLAG_CLEAR;
                                o_result.read_data = i_item.keyboard_rows;
                            end else begin
                                o_result.read_data = i_state.f_dir_a;
                            end
                        end
                        ADDR_B_DATA: begin
                            if (i_state.f_regs[ADDR_B_CTRL][2]) begin
                                o_state.f_regs[ADDR_B_CTRL] =
                                    i_state.f_regs[ADDR_B_CTRL] & CTRL_FLAG_CLEAR;
                                o_result.read_data =
                                    i_state.f_regs[ADDR_B_DATA] & i_state.f_dir_b;
                            end else begin
                                o_result.read_data = i_state.f_dir_b;
                            end
                        end
                        default: o_result.read_data = i_state.f_regs[addr];
                    endcase
                end else begin
                    case (addr)
                        ADDR_A_DATA: begin
                            if (i_state.s_regs[ADDR_A_CTRL][2]) begin
                                o_state.s_regs[ADDR_A_CTRL] =
                                    i_state.s_regs[ADDR_A_CTRL] & CTRL_FLAG_CLEAR;
                                o_result.read_data = i_state.s_regs[ADDR_A_DATA];
                            end else begin
                                o_result.read_data = i_state.s_dir_a;
                            end
                        end
                        ADDR_B_DATA: begin
                            if (i_state.s_regs[ADDR_B_CTRL][2]) begin
                                o_state.s_regs[ADDR_B_CTRL] =
                                    i_state.s_regs[ADDR_B_CTRL] & CTRL_FLAG_CLEAR;
                                o_result.read_data =
                                    i_state.s_regs[ADDR_B_DATA] & i_state.s_dir_b;
                            end else begin
                                o_result.read_data = i_state.s_dir_b;
                            end
                        end
                        default: o_result.read_data = i_state.s_regs[addr];
                    endcase
                end
            end

            // Register write
            CMD_WRITE: begin
                if (!second) begin
                    case (addr)
                        ADDR_A_DATA: begin
                            if (i_state.f_regs[ADDR_A_CTRL][2]) begin
                                o_state.f_regs[ADDR_A_DATA] = i_item.write_data;
                            end else begin
                                o_state.f_dir_a = i_item.write_data;
                            end
                        end
                        ADDR_B_DATA: begin
                            if (i_state.f_regs[ADDR_B_CTRL][2]) begin
                                o_state.f_regs[ADDR_B_DATA] = i_item.write_data;
                            end else begin
                                o_state.f_dir_b = i_item.write_data;
                            end
                        end
                        default: o_state.f_regs[addr] = i_item.write_data & CTRL_WRITE_MASK;
                    endcase
                end else begin
                    case (addr)
                        // DAC write: capture, discharge detection
                        ADDR_A_DATA: begin
                            if (i_state.s_regs[ADDR_A_CTRL][2]) begin
                                o_state.s_regs[ADDR_A_DATA] = i_item.write_data;
                                if (mux_zero) begin
                                    if (i_state.s_regs[ADDR_B_CTRL][3]) begin
                                        o_state.audio = {i_item.write_data[7:2], 1'b0};
                                    end else begin
                                        o_state.cassette = {i_item.write_data[7:2], 2'b00};
                                    end
                                end
                                if (i_state.charge_high && level == '0) begin
                                    o_state.discharge = 1'b1;
                                    o_state.s_regs[ADDR_A_DATA] =
                                        i_item.write_data & DAC_TOP_CLEAR;
                                end
                                o_state.charge_high = (level == DAC_FULL);
                            end else begin
                                o_state.s_dir_a = i_item.write_data;
                            end
                        end
                        ADDR_B_DATA: begin
                            if (i_state.s_regs[ADDR_B_CTRL][2]) begin
                                o_state.s_regs[ADDR_B_DATA] = masked;
                                o_state.sound = masked[1];
                            end else begin
                                o_state.s_dir_b = i_item.write_data;
                            end
                        end
                        default: o_state.s_regs[addr] = i_item.write_data & CTRL_WRITE_MASK;
                    endcase
                end
            end

            // Horizontal sync edge on first adapter A side
            CMD_HSYNC: begin
                case (i_item.edge_kind)
                    EDGE_FALL: hit = !i_state.f_regs[ADDR_A_CTRL][1];
                    EDGE_RISE: hit = i_state.f_regs[ADDR_A_CTRL][1];
                    EDGE_ANY:  hit = 1'b1;
                    default:   hit = 1'b0;
                endcase
                if (hit) begin
                    o_state.f_regs[ADDR_A_CTRL][7] = 1'b1;
                    o_result.irq_assert = i_state.f_regs[ADDR_A_CTRL][0];
                end
            end

            // Vertical sync edge on first adapter B side, plus cart interrupt
            CMD_VSYNC: begin
                if (i_cart.inserted && i_cart.autostart) begin
                    o_state.s_regs[ADDR_B_CTRL][7] = 1'b1;
                    o_result.firq_action = i_state.s_regs[ADDR_B_CTRL][0] ?
                                           FIRQ_ASSERT : FIRQ_DEASSERT;
                end
                case (i_item.edge_kind)
                    EDGE_FALL: hit = !i_state.f_regs[ADDR_B_CTRL][1];
                    EDGE_RISE: hit = i_state.f_regs[ADDR_B_CTRL][1];
                    default:   hit = 1'b0;
                endcase
                if (hit) begin
                    o_state.f_regs[ADDR_B_CTRL][7] = 1'b1;
                    o_result.irq_assert = i_state.f_regs[ADDR_B_CTRL][0];
                end
            end

            // Cassette input comparator into DAC data bit 0
            CMD_CASS: begin
                o_state.s_regs[ADDR_A_DATA][0] = i_item.write_data[7];
            end

            // Cartridge assert
            CMD_CART: begin
                o_state.s_regs[ADDR_B_CTRL][7] = 1'b1;
                o_result.firq_action = i_state.s_regs[ADDR_B_CTRL][0] ?
                                       FIRQ_ASSERT : FIRQ_DEASSERT;
            end

            default: begin
            end
        endcase

        // Status taken from the updated state
        o_result.dac_level       = o_state.s_regs[ADDR_A_DATA][7:2];
        o_result.mux_select      = {o_state.f_regs[ADDR_B_CTRL][3],
                                    o_state.f_regs[ADDR_A_CTRL][3]};
        o_result.video_mode      = o_state.s_regs[ADDR_B_DATA][7:3];
        o_result.motor_on        = o_state.s_regs[ADDR_A_CTRL][3];
        o_result.audio_level     = o_state.audio;
        o_result.cassette_level  = o_state.cassette;
        o_result.sound_level     = o_state.sound;
        o_result.keyboard_column = o_state.f_regs[ADDR_B_DATA];
        o_result.discharge_seen  = o_state.discharge;
    end

endmodule
`default_nettype wire
